FILE: hdl/integer_array_table_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef INTEGER_ARRAY_TABLE_ENGINE_ASSERT_SVH
`define INTEGER_ARRAY_TABLE_ENGINE_ASSERT_SVH

// Checked only outside reset.
`define IATE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define IATE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/iate_pkg.sv
package iate_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int SUM_W = WORD_W + IDX_W;

  typedef logic [3:0] op_t;
  typedef logic [2:0] status_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam op_t OP_LIST = 4'd0;
  localparam op_t OP_SUM = 4'd1;
  localparam op_t OP_EVEN = 4'd2;
  localparam op_t OP_ODD = 4'd3;
  localparam op_t OP_MAX = 4'd4;
  localparam op_t OP_MIN = 4'd5;
  localparam op_t OP_SORT = 4'd6;
  localparam op_t OP_SEARCH = 4'd7;
  localparam op_t OP_REPLACE = 4'd8;
  localparam op_t OP_DELETE = 4'd9;
  localparam op_t OP_INSERT = 4'd10;

  localparam status_t ST_OK = 3'd0;
  localparam status_t ST_BADIDX = 3'd1;
  localparam status_t ST_FULL = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_EMPTY = 3'd4;
endpackage

FILE: hdl/iate_req_if.sv
interface iate_req_if;
  import iate_pkg::*;
  logic valid;
  logic ready;
  op_t op;
  logic [CNT_W-1:0] position;
  word_t operand_value;
  modport source(output valid, op, position, operand_value, input ready);
  modport sink(input valid, op, position, operand_value, output ready);
endinterface

FILE: hdl/iate_rsp_if.sv
interface iate_rsp_if;
  import iate_pkg::*;
  logic valid;
  logic ready;
  status_t status;
  sum_t result_value;
  idx_t result_index;
  word_t mean;
  logic last;
  modport source(output valid, status, result_value, result_index, mean, last, input ready);
  modport sink(input valid, status, result_value, result_index, mean, last, output ready);
endinterface

FILE: hdl/iate_div.sv
module iate_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  iate_pkg::sum_t dividend,
  input  iate_pkg::cnt_t divisor,
  output logic done,
  output iate_pkg::word_t quotient
);
  import iate_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic busy;
  logic neg;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0] q;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0] rem_sh;
  logic ge;

  assign rem_sh = {rem, q[SUM_W-1]};
  assign ge = rem_sh >= {1'b0, divisor};
  assign quotient = neg ? -word_t'(q[WORD_W-1:0]) : word_t'(q[WORD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg <= dividend[SUM_W-1];
        q <= dividend[SUM_W-1] ? -dividend : dividend;
        rem <= '0;
      end else if (busy) begin
        rem <= ge ? CNT_W'(rem_sh - {1'b0, divisor}) : CNT_W'(rem_sh);
        q <= {q[SUM_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/integer_array_table_engine.sv
// From accept to last beat: list, sum, even, odd and search read the entries one by one,
// max and min walk the table twice, sum/mean then waits for the serial divider, and sort
// runs compare-exchange passes before it lists the table. Insert and delete shift the
// entries behind the position; output stalls lengthen every operation.
// One request at a time; results leave through one output register.
// Reset (synchronous, rst high): count is DEPTH and entry k reads as k until first written.
module integer_array_table_engine (
  input logic clk,
  input logic rst,
  iate_req_if.sink req,
  iate_rsp_if.source rsp
);
  import iate_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD = 5'd1;
  localparam logic [4:0] S_USE = 5'd2;
  localparam logic [4:0] S_END = 5'd3;
  localparam logic [4:0] S_DIV = 5'd4;
  localparam logic [4:0] S_RESP = 5'd5;
  localparam logic [4:0] S_DEL_G = 5'd6;
  localparam logic [4:0] S_DL_RD = 5'd7;
  localparam logic [4:0] S_DL_WR = 5'd8;
  localparam logic [4:0] S_IN_RD = 5'd9;
  localparam logic [4:0] S_IN_WR = 5'd10;
  localparam logic [4:0] S_SO_I = 5'd11;
  localparam logic [4:0] S_SO_LI = 5'd12;
  localparam logic [4:0] S_SO_RJ = 5'd13;
  localparam logic [4:0] S_SO_CJ = 5'd14;

  logic [4:0] state;
  op_t op_q;
  cnt_t pos_q;
  word_t val_q;
  cnt_t cnt;
  cnt_t i;
  cnt_t j;
  word_t cur;
  word_t best;
  sum_t sum;
  logic second;
  logic hold_v;
  status_t resp_st;
  sum_t resp_val;
  idx_t resp_idx;
  word_t resp_mean;

  word_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  word_t rd_q;
  logic rd_vld;
  idx_t rd_addr;
  idx_t ra;
  logic we;
  idx_t wa;
  word_t wd;
  word_t d;

  logic slot;
  logic push;
  logic push_last;
  logic accept;
  logic is_emit;
  logic match;
  logic div_start;
  logic div_done;
  word_t div_q;

  assign d = rd_vld ? rd_q : word_t'(rd_addr);
  assign accept = req.valid && req.ready;
  assign req.ready = state == S_IDLE;
  assign slot = !rsp.valid || rsp.ready;

  always_comb begin
    is_emit = 1'b0;
    match = 1'b0;
    case (op_q)
      OP_LIST, OP_SORT: begin
        is_emit = 1'b1;
        match = 1'b1;
      end
      OP_EVEN: begin
        is_emit = 1'b1;
        match = !d[0];
      end
      OP_ODD: begin
        is_emit = 1'b1;
        match = d[0];
      end
      OP_MAX, OP_MIN: begin
        is_emit = second;
        match = d == best;
      end
      default: begin
        is_emit = 1'b0;
        match = 1'b0;
      end
    endcase
  end

  always_comb begin
    ra = i[IDX_W-1:0];
    we = 1'b0;
    wa = '0;
    wd = val_q;
    case (state)
      S_IDLE: begin
        ra = req.position[IDX_W-1:0];
        if (accept && req.op == OP_REPLACE && req.position < cnt) begin
          we = 1'b1;
          wa = req.position[IDX_W-1:0];
          wd = req.operand_value;
        end
      end
      S_DL_RD: ra = IDX_W'(j + 1'b1);
      S_DL_WR: begin
        we = 1'b1;
        wa = j[IDX_W-1:0];
        wd = d;
      end
      S_IN_RD: begin
        ra = IDX_W'(j - 1'b1);
        if (j == pos_q) begin
          we = 1'b1;
          wa = pos_q[IDX_W-1:0];
          wd = val_q;
        end
      end
      S_IN_WR: begin
        we = 1'b1;
        wa = j[IDX_W-1:0];
        wd = d;
      end
      S_SO_RJ: begin
        ra = j[IDX_W-1:0];
        if (j >= cnt) begin
          we = 1'b1;
          wa = i[IDX_W-1:0];
          wd = cur;
        end
      end
      S_SO_CJ: begin
        if (d < cur) begin
          we = 1'b1;
          wa = j[IDX_W-1:0];
          wd = cur;
        end
      end
      default: ra = i[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
    rd_addr <= ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[ra] || (we && wa == ra);
      if (we) begin
        vld[wa] <= 1'b1;
      end
    end
  end

  assign push = (state == S_RESP && slot) ||
                (state == S_USE && is_emit && match && hold_v && slot);
  assign push_last = state == S_RESP;
  assign div_start = state == S_END && op_q == OP_SUM && cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp.status <= resp_st;
      rsp.result_value <= resp_val;
      rsp.result_index <= resp_idx;
      rsp.mean <= resp_mean;
      rsp.last <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= CNT_W'(DEPTH);
      hold_v <= 1'b0;
      second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= req.op;
            pos_q <= req.position;
            val_q <= req.operand_value;
            i <= '0;
            sum <= '0;
            second <= 1'b0;
            hold_v <= 1'b0;
            resp_st <= ST_EMPTY;
            resp_val <= '0;
            resp_idx <= '0;
            resp_mean <= '0;
            case (req.op)
              OP_LIST, OP_SUM, OP_EVEN, OP_ODD, OP_MAX, OP_MIN, OP_SEARCH: state <= S_RD;
              OP_SORT: state <= S_SO_I;
              OP_REPLACE: begin
                if (req.position >= cnt) begin
                  resp_st <= ST_BADIDX;
                end else begin
                  resp_st <= ST_OK;
                  resp_val <= SUM_W'(req.operand_value);
                  resp_idx <= req.position[IDX_W-1:0];
                end
                state <= S_RESP;
              end
              OP_DELETE: begin
                if (req.position >= cnt) begin
                  resp_st <= ST_BADIDX;
                  state <= S_RESP;
                end else begin
                  state <= S_DEL_G;
                end
              end
              OP_INSERT: begin
                if (cnt >= CNT_W'(DEPTH)) begin
                  resp_st <= ST_FULL;
                  state <= S_RESP;
                end else if (req.position > cnt) begin
                  resp_st <= ST_BADIDX;
                  state <= S_RESP;
                end else begin
                  resp_st <= ST_OK;
                  resp_val <= SUM_W'(req.operand_value);
                  resp_idx <= req.position[IDX_W-1:0];
                  j <= cnt;
                  state <= S_IN_RD;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_RD: state <= (i == cnt) ? S_END : S_USE;
        S_USE: begin
          if (op_q == OP_SUM) begin
            sum <= sum + SUM_W'(d);
            i <= i + 1'b1;
            state <= S_RD;
          end else if ((op_q == OP_MAX || op_q == OP_MIN) && !second) begin
            if (i == '0 || (op_q == OP_MAX ? d > best : d < best)) begin
              best <= d;
            end
            i <= i + 1'b1;
            state <= S_RD;
          end else if (op_q == OP_SEARCH) begin
            if (d == val_q) begin
              resp_st <= ST_OK;
              resp_val <= SUM_W'(val_q);
              resp_idx <= i[IDX_W-1:0];
              state <= S_RESP;
            end else begin
              i <= i + 1'b1;
              state <= S_RD;
            end
          end else if (match && is_emit) begin
            if (!hold_v || slot) begin
              hold_v <= 1'b1;
              resp_st <= ST_OK;
              resp_val <= SUM_W'(d);
              resp_idx <= i[IDX_W-1:0];
              i <= i + 1'b1;
              state <= S_RD;
            end
          end else begin
            i <= i + 1'b1;
            state <= S_RD;
          end
        end
        S_END: begin
          if (op_q == OP_SUM) begin
            state <= (cnt == '0) ? S_RESP : S_DIV;
          end else if ((op_q == OP_MAX || op_q == OP_MIN) && !second) begin
            if (cnt == '0) begin
              state <= S_RESP;
            end else begin
              second <= 1'b1;
              i <= '0;
              state <= S_RD;
            end
          end else if (op_q == OP_SEARCH) begin
            resp_st <= ST_NOTFOUND;
            resp_val <= SUM_W'(val_q);
            state <= S_RESP;
          end else begin
            state <= S_RESP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            resp_st <= ST_OK;
            resp_val <= sum;
            resp_mean <= div_q;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot) begin
            state <= S_IDLE;
          end
        end
        S_DEL_G: begin
          resp_st <= ST_OK;
          resp_val <= SUM_W'(d);
          resp_idx <= pos_q[IDX_W-1:0];
          j <= pos_q;
          state <= S_DL_RD;
        end
        S_DL_RD: begin
          if (j + 1'b1 >= cnt) begin
            cnt <= cnt - 1'b1;
            state <= S_RESP;
          end else begin
            state <= S_DL_WR;
          end
        end
        S_DL_WR: begin
          j <= j + 1'b1;
          state <= S_DL_RD;
        end
        S_IN_RD: begin
          if (j == pos_q) begin
            cnt <= cnt + 1'b1;
            state <= S_RESP;
          end else begin
            state <= S_IN_WR;
          end
        end
        S_IN_WR: begin
          j <= j - 1'b1;
          state <= S_IN_RD;
        end
        S_SO_I: begin
          if (i + 1'b1 >= cnt) begin
            i <= '0;
            state <= S_RD;
          end else begin
            state <= S_SO_LI;
          end
        end
        S_SO_LI: begin
          cur <= d;
          j <= i + 1'b1;
          state <= S_SO_RJ;
        end
        S_SO_RJ: begin
          if (j >= cnt) begin
            i <= i + 1'b1;
            state <= S_SO_I;
          end else begin
            state <= S_SO_CJ;
          end
        end
        S_SO_CJ: begin
          if (d < cur) begin
            cur <= d;
          end
          j <= j + 1'b1;
          state <= S_SO_RJ;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  iate_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(sum),
    .divisor(cnt),
    .done(div_done),
    .quotient(div_q)
  );
endmodule

FILE: hdl/iate_checker.sv
`include "integer_array_table_engine_assert.svh"

module iate_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input iate_pkg::status_t rsp_status,
  input iate_pkg::sum_t rsp_value,
  input iate_pkg::word_t rsp_mean,
  input logic rsp_last
);
  import iate_pkg::*;

  `IATE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value), "stalled beat changed")
  `IATE_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")
  `IATE_ASSERT(a_error_last, rsp_valid && rsp_status != ST_OK |-> rsp_last, "error beat not last")
  `IATE_ASSERT(a_mean_last, rsp_valid && rsp_mean != '0 |-> rsp_last && rsp_status == ST_OK, "mean on a list beat")
endmodule

bind integer_array_table_engine iate_checker u_chk (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.status),
  .rsp_value(rsp.result_value),
  .rsp_mean(rsp.mean),
  .rsp_last(rsp.last)
);
